// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is asserted.
`define ASSERT_CLK(name, prop) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error("fpsqrt assertion failed");

// Clocked assertion, also checked during reset.
`define ASSERT_RST(name, prop) \
	name: assert property (@(posedge clk) prop) \
	else $error("fpsqrt reset assertion failed");

`endif

// ===== rtl/fpsqrt_pkg.sv =====
// ----------------------------------------------------------------------------
// fpsqrt_pkg
// Widths and constants of the fixed-point square root.
// ----------------------------------------------------------------------------
package fpsqrt_pkg;

	localparam int RAD_W           = 32;
	localparam int ROOT_W          = 24;
	localparam int FRAC_BITS_DEF   = 16;
	localparam int STEPS_PER_STAGE = 3;

	localparam logic [ROOT_W-1:0] ROOT_MAX = '1;

endpackage

// ===== rtl/fpsqrt_arg_if.sv =====
// ----------------------------------------------------------------------------
// fpsqrt_arg_if
// Radicand channel: valid, ready and a signed fixed-point radicand.
// ----------------------------------------------------------------------------
interface fpsqrt_arg_if;

	logic                                  valid;
	logic                                  ready;
	logic signed [fpsqrt_pkg::RAD_W-1:0]   radicand;

	modport source (output valid, output radicand, input ready);
	modport sink   (input valid, input radicand, output ready);

endinterface

// ===== rtl/fpsqrt_res_if.sv =====
// ----------------------------------------------------------------------------
// fpsqrt_res_if
// Result channel: valid, ready, root and the negative-radicand flag.
// ----------------------------------------------------------------------------
interface fpsqrt_res_if;

	logic                            valid;
	logic                            ready;
	logic [fpsqrt_pkg::ROOT_W-1:0]   root;
	logic                            negative_input;

	modport source (output valid, output root, output negative_input, input ready);
	modport sink   (input valid, input root, input negative_input, output ready);

endinterface

// ===== rtl/fixed_point_square_root_top.sv =====
// ----------------------------------------------------------------------------
// fixed_point_square_root_top
// Pipelined floor square root of a signed fixed-point radicand.
// ----------------------------------------------------------------------------
// Takes one radicand per cycle unless the output stalls, and returns one
// result per radicand, in order. The root is floor(sqrt(r * 2^FRAC_BITS)) for
// the radicand bits r, so it keeps FRAC_BITS fraction bits and is truncated,
// never rounded; it saturates to all ones if it would not fit in the 24-bit
// root field. A negative radicand returns a root of zero with negative_input
// set. Throughput is one transfer per cycle unless the output stalls. The
// restoring root produces one root bit per digit step, and each pipeline
// stage holds up to three digit steps. A stalled output holds its result
// while the stages behind it keep filling bubbles.
module fixed_point_square_root_top #(
	parameter int FRAC_BITS = fpsqrt_pkg::FRAC_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	fpsqrt_arg_if.sink    arg,
	fpsqrt_res_if.source  result
);

	import fpsqrt_pkg::*;

	localparam int OP_BITS = RAD_W - 1 + FRAC_BITS;
	localparam int RW      = (OP_BITS + 1) / 2;
	localparam int OPW     = 2 * RW;
	localparam int NST     = (RW + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

	logic           valid_w [NST+1];
	logic           ready_w [NST+1];
	logic [OPW-1:0] op_w    [NST+1];
	logic [RW:0]    rem_w   [NST+1];
	logic [RW-1:0]  root_w  [NST+1];
	logic           neg_w   [NST+1];

	assign valid_w[0] = arg.valid;
	assign arg.ready  = ready_w[0];
	assign neg_w[0]   = arg.radicand[RAD_W-1];
	assign op_w[0]    = arg.radicand[RAD_W-1] ? '0
		: (OPW'(arg.radicand[RAD_W-2:0]) << FRAC_BITS);
	assign rem_w[0]   = '0;
	assign root_w[0]  = '0;

	for (genvar s = 0; s < NST; s++) begin : g_stage
		localparam int LEFT  = RW - s * STEPS_PER_STAGE;
		localparam int NSTEP = (LEFT < STEPS_PER_STAGE) ? LEFT : STEPS_PER_STAGE;

		fpsqrt_stage #(
			.RW    (RW),
			.OPW   (OPW),
			.STEPS (NSTEP)
		) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (valid_w[s]),
			.in_ready  (ready_w[s]),
			.in_op     (op_w[s]),
			.in_rem    (rem_w[s]),
			.in_root   (root_w[s]),
			.in_neg    (neg_w[s]),
			.out_valid (valid_w[s+1]),
			.out_ready (ready_w[s+1]),
			.out_op    (op_w[s+1]),
			.out_rem   (rem_w[s+1]),
			.out_root  (root_w[s+1]),
			.out_neg   (neg_w[s+1])
		);
	end

	assign result.valid          = valid_w[NST];
	assign ready_w[NST]          = result.ready;
	assign result.negative_input = neg_w[NST];

	if (RW > ROOT_W) begin : g_sat
		assign result.root = (|root_w[NST][RW-1:ROOT_W]) ? ROOT_MAX
			: root_w[NST][ROOT_W-1:0];
	end else begin : g_ext
		assign result.root = ROOT_W'(root_w[NST]);
	end

endmodule

// ===== rtl/fpsqrt_stage.sv =====
// ----------------------------------------------------------------------------
// fpsqrt_stage
// One pipeline stage of the restoring square root: a few digit steps and a
// register with its own valid bit and ready.
// ----------------------------------------------------------------------------
module fpsqrt_stage #(
	parameter int RW    = 24,
	parameter int OPW   = 2 * RW,
	parameter int STEPS = 3
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [OPW-1:0]    in_op,
	input  logic [RW:0]       in_rem,
	input  logic [RW-1:0]     in_root,
	input  logic              in_neg,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [OPW-1:0]    out_op,
	output logic [RW:0]       out_rem,
	output logic [RW-1:0]     out_root,
	output logic              out_neg
);

	import fpsqrt_pkg::*;

	localparam int REM_W = RW + 1;
	localparam int EXT_W = RW + 3;

	logic [OPW-1:0]   op_d;
	logic [REM_W-1:0] rem_d;
	logic [RW-1:0]    root_d;

	logic             valid_q;
	logic [OPW-1:0]   op_q;
	logic [REM_W-1:0] rem_q;
	logic [RW-1:0]    root_q;
	logic             neg_q;

	always_comb begin
		logic [EXT_W-1:0] ext;
		logic [EXT_W-1:0] trial;
		op_d   = in_op;
		rem_d  = in_rem;
		root_d = in_root;
		for (int i = 0; i < STEPS; i++) begin
			ext   = {rem_d, op_d[OPW-1 -: 2]};
			trial = EXT_W'({root_d, 2'b01});
			if (ext >= trial) begin
				rem_d  = REM_W'(ext - trial);
				root_d = {root_d[RW-2:0], 1'b1};
			end else begin
				rem_d  = REM_W'(ext);
				root_d = {root_d[RW-2:0], 1'b0};
			end
			op_d = op_d << 2;
		end
	end

	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_q   <= op_d;
			rem_q  <= rem_d;
			root_q <= root_d;
			neg_q  <= in_neg;
		end
	end

	assign out_valid = valid_q;
	assign out_op    = op_q;
	assign out_rem   = rem_q;
	assign out_root  = root_q;
	assign out_neg   = neg_q;

endmodule

// ===== rtl/fpsqrt_checker.sv =====
// ----------------------------------------------------------------------------
// fpsqrt_checker
// Port-level checks of the square root pipeline, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fpsqrt_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [fpsqrt_pkg::ROOT_W-1:0] root,
	input logic                          negative_input
);

	import fpsqrt_pkg::*;

	logic in_seen;

	assign in_seen = in_valid;

	`ASSERT_CLK(a_neg_zero_root, out_valid && negative_input |-> root == '0)

	`ASSERT_CLK(a_empty_ready, !out_valid |-> in_ready || !in_seen || in_ready)

	`ASSERT_CLK(a_stall_hold, out_valid && !out_ready |=> out_valid && $stable(root))

	`ASSERT_RST(a_reset_idle, !arst_n |-> !out_valid)

endmodule

bind fixed_point_square_root_top fpsqrt_checker u_fpsqrt_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (arg.valid),
	.in_ready       (arg.ready),
	.out_valid      (result.valid),
	.out_ready      (result.ready),
	.root           (result.root),
	.negative_input (result.negative_input)
);

// ===== sim/fixed_point_square_root_top_test.sv =====
// ----------------------------------------------------------------------------
// fixed_point_square_root_top_test
// Self-checking bench for the pipelined fixed-point square root.
// ----------------------------------------------------------------------------
// Sends signed Q15.16 radicands through the argument channel and checks every
// root and negative flag against an exact digit-by-digit floor square root
// computed in the bench. A short directed list covers zero, the field
// extremes, negative values and perfect-square boundaries; random radicands
// follow, mixing full-range, small, negative, near-maximum and near-square
// values. The sender works in bursts with random gaps and the receiver
// stalls in changing modes.
// ----------------------------------------------------------------------------
module fixed_point_square_root_top_test;

	import fpsqrt_pkg::*;

	localparam int FRAC        = FRAC_BITS_DEF;
	localparam int RANDOM_ITEMS = 1000;
	localparam int DRAIN_CYCLES = 20;
	localparam longint MAX_POS_ROOT = 11863283;

	typedef struct packed {
		logic [ROOT_W-1:0] root;
		logic              negative_input;
	} root_result_t;

	class root_scoreboard;
		root_result_t pending[$];
		int           errors;

		function new();
			errors = 0;
		endfunction

		function automatic root_result_t predict_root(logic [RAD_W-1:0] rad);
			root_result_t res;
			logic [63:0]  rem;
			logic [63:0]  acc;
			logic [63:0]  step;
			res.root = '0;
			res.negative_input = rad[RAD_W-1];
			if (!rad[RAD_W-1]) begin
				rem = {32'b0, rad} << FRAC;
				acc = '0;
				step = 64'h1 << 62;
				while (step > rem)
					step = step >> 2;
				while (step != 0) begin
					if (rem >= acc + step) begin
						rem = rem - (acc + step);
						acc = (acc >> 1) + step;
					end else begin
						acc = acc >> 1;
					end
					step = step >> 2;
				end
				res.root = (acc > {40'b0, ROOT_MAX}) ? ROOT_MAX : acc[ROOT_W-1:0];
			end
			return res;
		endfunction

		task report(input string msg);
			$display("%0t: mismatch: %s", $realtime, msg);
			errors++;
		endtask

		function void note_radicand(logic [RAD_W-1:0] rad);
			pending.push_back(predict_root(rad));
		endfunction

		task check_result(input logic [ROOT_W-1:0] root, input logic negative_input);
			root_result_t want;
			if (pending.size() == 0) begin
				report($sformatf("unexpected result root=%h neg=%b", root, negative_input));
			end else begin
				want = pending.pop_front();
				if (root !== want.root)
					report($sformatf("root %h, expected %h", root, want.root));
				if (negative_input !== want.negative_input)
					report($sformatf("negative_input %b, expected %b",
						negative_input, want.negative_input));
			end
		endtask
	endclass

	logic clk;
	logic arst_n;

	fpsqrt_arg_if arg_ch();
	fpsqrt_res_if res_ch();

	root_scoreboard tracker;

	int burst_left;

	fixed_point_square_root_top #(
		.FRAC_BITS(FRAC)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.arg   (arg_ch),
		.result(res_ch)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#3000000;
		$display("fixed_point_square_root_top test failed");
		$finish;
	end

	task automatic send_radicand(input logic [RAD_W-1:0] value);
		int gap;
		arg_ch.valid <= 1'b1;
		arg_ch.radicand <= value;
		do @(posedge clk); while (!arg_ch.ready);
		tracker.note_radicand(value);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				arg_ch.valid <= 1'b0;
				arg_ch.radicand <= $urandom;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
				: $urandom_range(0, 20);
		end
	endtask

	function automatic logic [RAD_W-1:0] pick_radicand();
		logic [63:0] sq;
		longint      r;
		case ($urandom_range(0, 9))
			0, 1, 2: pick_radicand = $urandom;
			3: pick_radicand = $urandom_range(0, 255);
			4: pick_radicand = {1'b1, 31'($urandom)};
			5: pick_radicand = 32'h7FFF_FFFF - $urandom_range(0, 1023);
			default: begin
				r = $urandom_range(0, int'(MAX_POS_ROOT));
				sq = 64'(r * r);
				case ($urandom_range(0, 2))
					0: sq = sq >> FRAC;
					1: sq = (sq + 64'hFFFF) >> FRAC;
					default: sq = (sq >> FRAC) - ((sq >> FRAC) != 0 ? 64'd1 : 64'd0);
				endcase
				pick_radicand = (sq > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : sq[31:0];
			end
		endcase
	endfunction

	// receiver: switch between always ready, random, mostly stalled and periodic
	int mode;
	int mode_left;
	int phase;
	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready)
			tracker.check_result(res_ch.root, res_ch.negative_input);
		if (mode_left == 0) begin
			mode = $urandom_range(0, 3);
			mode_left = $urandom_range(10, 200);
			phase = 0;
		end else begin
			mode_left--;
			phase++;
		end
		case (mode)
			0: res_ch.ready <= 1'b1;
			1: res_ch.ready <= $urandom_range(0, 1);
			2: res_ch.ready <= ($urandom_range(0, 5) == 0);
			default: res_ch.ready <= (phase % 7) < 4;
		endcase
	end

	logic [RAD_W-1:0] directed[] = '{
		32'h0000_0000, 32'h0000_0001, 32'h0000_0002, 32'h0000_0003,
		32'h0000_8000, 32'h0000_FFFF, 32'h0001_0000, 32'h0001_0001,
		32'h0004_0000, 32'h0003_FFFF, 32'h0009_0000, 32'h0064_0000,
		32'h4000_0000, 32'h3FFF_FFFF, 32'h7FFF_0000, 32'h7FFF_FFFF,
		32'h7FFF_FFFE, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_0000,
		32'hAAAA_AAAA, 32'h5555_5555, 32'hC000_0001
	};

	initial begin
		tracker = new();
		burst_left = 0;
		mode = 0;
		mode_left = 0;
		phase = 0;
		arst_n = 1'b0;
		arg_ch.valid = 1'b0;
		arg_ch.radicand = '0;
		res_ch.ready = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			send_radicand(directed[i]);
		for (int n = 0; n < RANDOM_ITEMS; n++)
			send_radicand(pick_radicand());

		arg_ch.valid <= 1'b0;
		while (tracker.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (tracker.errors == 0)
			$display("fixed_point_square_root_top test passed");
		else
			$display("fixed_point_square_root_top test failed");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/fpsqrt_pkg.sv
rtl/fpsqrt_arg_if.sv
rtl/fpsqrt_res_if.sv
rtl/fpsqrt_stage.sv
rtl/fixed_point_square_root_top.sv
rtl/fpsqrt_checker.sv
sim/fixed_point_square_root_top_test.sv
